>>> hw/rtl/rrs_pkg.sv
// shared types and constants for the reserved range region splitter
`default_nettype none

package rrs_pkg;

    localparam int ADDR_W   = 48;
    localparam int END_W    = ADDR_W + 1;
    localparam int ATTR_W   = 32;
    localparam int NUM_RNG  = 3;
    localparam int RNG_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [ATTR_W-1:0] ATTR_PRESENT_ONLY = 32'h0000_0001;

    localparam logic KIND_NORMAL   = 1'b0;
    localparam logic KIND_RESERVED = 1'b1;

    localparam logic [RNG_W-1:0] RNG_LAST = 2'd2;

    // register index: bits [2:1] pick the range, bit 0 picks base or size
    localparam logic CFG_SEL_BASE = 1'b0;
    localparam logic CFG_SEL_SIZE = 1'b1;

    localparam logic [ADDR_W-1:0] RST_BASE_A = 48'h0;
    localparam logic [ADDR_W-1:0] RST_SIZE_A = 48'h0000_0020_0000;
    localparam logic [ADDR_W-1:0] RST_BASE_B = 48'h0000_0840_0000;
    localparam logic [ADDR_W-1:0] RST_SIZE_B = 48'h0000_01E0_0000;
    localparam logic [ADDR_W-1:0] RST_BASE_C = 48'h0;
    localparam logic [ADDR_W-1:0] RST_SIZE_C = 48'h0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REND,
        ST_RESE,
        ST_CHK_LO,
        ST_CHK_HI,
        ST_OB,
        ST_OE,
        ST_GAP,
        ST_RSV,
        ST_TAIL,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/reserved_range_region_splitter.sv
// reserved range region splitter top level: sequencer around one shared add/subtract unit
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------------------
//  request   | start in, busy out         | region_base, region_size, region_attributes
//  segment   | seg_valid out (1 cycle)    | seg_base, seg_length, seg_kind, seg_attributes,
//            |                            | seg_last
//  config    | cfg_valid in, cfg_ready out| cfg_index, cfg_data
//
//  busy is high as the sequencer forms the region end, then checks each range against the
//  cursor and the region end; an overlap adds its bounds, any gap segment before it and its
//  reserved segment; a tail segment and a flush end the request. every sum and check uses
//  the single 49-bit adder. a start is taken once busy is low; a zero-size request gives no
//  segment. segments trail the unit by one pending stage so the last one can be marked; it
//  is out in the first cycle busy is low. rst_n clears the sequencer, the strobe and the
//  range registers to their defaults. the receiver cannot stall; cfg_ready is always high.
`default_nettype none

module reserved_range_region_splitter
    import rrs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [ADDR_W-1:0]    region_base,
    input  wire logic [ADDR_W-1:0]    region_size,
    input  wire logic [ATTR_W-1:0]    region_attributes,
    output logic                      seg_valid,
    output logic [ADDR_W-1:0]         seg_base,
    output logic [ADDR_W-1:0]         seg_length,
    output logic                      seg_kind,
    output logic [ATTR_W-1:0]         seg_attributes,
    output logic                      seg_last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] rbase_reg [NUM_RNG];
    logic [ADDR_W-1:0] rsize_reg [NUM_RNG];

    logic [END_W-1:0]  rend_reg, rend_next;
    logic [END_W-1:0]  cur_reg, cur_next;
    logic [END_W-1:0]  rese_reg, rese_next;
    logic [END_W-1:0]  ob_reg, ob_next;
    logic [END_W-1:0]  oe_reg, oe_next;
    logic              gap_reg, gap_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [RNG_W-1:0]  rng_reg, rng_next;

    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_base_reg, pend_base_next;
    logic [ADDR_W-1:0] pend_len_reg, pend_len_next;
    logic              pend_kind_reg, pend_kind_next;
    logic [ATTR_W-1:0] pend_attr_reg, pend_attr_next;

    logic              seg_valid_reg, seg_valid_next;
    logic [ADDR_W-1:0] seg_base_reg, seg_base_next;
    logic [ADDR_W-1:0] seg_length_reg, seg_length_next;
    logic              seg_kind_reg, seg_kind_next;
    logic [ATTR_W-1:0] seg_attr_reg, seg_attr_next;
    logic              seg_last_reg, seg_last_next;

    // shared unit
    logic [END_W-1:0] op_a, op_b;
    logic             op_sub;
    logic [END_W:0]   alu_res;
    logic             alu_ge;
    logic             alu_nz;

    logic [END_W-1:0] cur_resb;
    logic [END_W-1:0] cur_ress;

    logic              emit;
    logic [ADDR_W-1:0] emit_base;
    logic [ADDR_W-1:0] emit_len;
    logic              emit_kind;
    logic [ATTR_W-1:0] emit_attr;
    logic              flush;

    logic              cfg_hit;

    assign cur_resb = {1'b0, rbase_reg[rng_reg]};
    assign cur_ress = {1'b0, rsize_reg[rng_reg]};

    assign alu_res = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + {{END_W{1'b0}}, op_sub};
    assign alu_ge  = alu_res[END_W];
    assign alu_nz  = |alu_res[END_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        rend_next  = rend_reg;
        cur_next   = cur_reg;
        rese_next  = rese_reg;
        ob_next    = ob_reg;
        oe_next    = oe_reg;
        gap_next   = gap_reg;
        attr_next  = attr_reg;
        rng_next   = rng_reg;
        op_a       = cur_reg;
        op_b       = rend_reg;
        op_sub     = 1'b0;
        emit       = 1'b0;
        emit_base  = cur_reg[ADDR_W-1:0];
        emit_len   = alu_res[ADDR_W-1:0];
        emit_kind  = KIND_NORMAL;
        emit_attr  = attr_reg;
        flush      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cur_next  = {1'b0, region_base};
                    rend_next = {1'b0, region_size};
                    attr_next = region_attributes;
                    rng_next  = '0;
                    if (|region_size)
                        state_next = ST_REND;
                end
            end
            ST_REND:
            begin
                op_a       = cur_reg;
                op_b       = rend_reg;
                rend_next  = alu_res[END_W-1:0];
                state_next = ST_RESE;
            end
            ST_RESE:
            begin
                op_a       = cur_resb;
                op_b       = cur_ress;
                rese_next  = alu_res[END_W-1:0];
                state_next = ST_CHK_LO;
            end
            ST_CHK_LO:
            begin
                // range ends at or before the cursor
                op_a   = cur_reg;
                op_b   = rese_reg;
                op_sub = 1'b1;
                if (alu_ge)
                begin
                    rng_next   = rng_reg + 1'b1;
                    state_next = (rng_reg == RNG_LAST) ? ST_TAIL : ST_RESE;
                end
                else
                    state_next = ST_CHK_HI;
            end
            ST_CHK_HI:
            begin
                // range starts at or after the region end
                op_a   = cur_resb;
                op_b   = rend_reg;
                op_sub = 1'b1;
                if (alu_ge)
                begin
                    rng_next   = rng_reg + 1'b1;
                    state_next = (rng_reg == RNG_LAST) ? ST_TAIL : ST_RESE;
                end
                else
                    state_next = ST_OB;
            end
            ST_OB:
            begin
                op_a       = cur_reg;
                op_b       = cur_resb;
                op_sub     = 1'b1;
                gap_next   = !alu_ge;
                ob_next    = alu_ge ? cur_reg : cur_resb;
                state_next = ST_OE;
            end
            ST_OE:
            begin
                op_a       = rese_reg;
                op_b       = rend_reg;
                op_sub     = 1'b1;
                oe_next    = alu_ge ? rend_reg : rese_reg;
                state_next = gap_reg ? ST_GAP : ST_RSV;
            end
            ST_GAP:
            begin
                op_a       = ob_reg;
                op_b       = cur_reg;
                op_sub     = 1'b1;
                emit       = 1'b1;
                state_next = ST_RSV;
            end
            ST_RSV:
            begin
                op_a       = oe_reg;
                op_b       = ob_reg;
                op_sub     = 1'b1;
                emit       = 1'b1;
                emit_base  = ob_reg[ADDR_W-1:0];
                emit_kind  = KIND_RESERVED;
                emit_attr  = ATTR_PRESENT_ONLY;
                cur_next   = oe_reg;
                rng_next   = rng_reg + 1'b1;
                state_next = (rng_reg == RNG_LAST) ? ST_TAIL : ST_RESE;
            end
            ST_TAIL:
            begin
                op_a       = rend_reg;
                op_b       = cur_reg;
                op_sub     = 1'b1;
                emit       = alu_ge && alu_nz;
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                flush      = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pending stage and output register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_base_next  = pend_base_reg;
        pend_len_next   = pend_len_reg;
        pend_kind_next  = pend_kind_reg;
        pend_attr_next  = pend_attr_reg;
        seg_valid_next  = 1'b0;
        seg_base_next   = seg_base_reg;
        seg_length_next = seg_length_reg;
        seg_kind_next   = seg_kind_reg;
        seg_attr_next   = seg_attr_reg;
        seg_last_next   = seg_last_reg;

        if (emit || flush)
        begin
            seg_valid_next  = pend_valid_reg;
            seg_base_next   = pend_base_reg;
            seg_length_next = pend_len_reg;
            seg_kind_next   = pend_kind_reg;
            seg_attr_next   = pend_attr_reg;
            seg_last_next   = flush;
        end
        if (emit)
        begin
            pend_valid_next = 1'b1;
            pend_base_next  = emit_base;
            pend_len_next   = emit_len;
            pend_kind_next  = emit_kind;
            pend_attr_next  = emit_attr;
        end
        else if (flush)
            pend_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            seg_valid_reg  <= 1'b0;
            rng_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            seg_valid_reg  <= seg_valid_next;
            rng_reg        <= rng_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rend_reg       <= rend_next;
        cur_reg        <= cur_next;
        rese_reg       <= rese_next;
        ob_reg         <= ob_next;
        oe_reg         <= oe_next;
        gap_reg        <= gap_next;
        attr_reg       <= attr_next;
        pend_base_reg  <= pend_base_next;
        pend_len_reg   <= pend_len_next;
        pend_kind_reg  <= pend_kind_next;
        pend_attr_reg  <= pend_attr_next;
        seg_base_reg   <= seg_base_next;
        seg_length_reg <= seg_length_next;
        seg_kind_reg   <= seg_kind_next;
        seg_attr_reg   <= seg_attr_next;
        seg_last_reg   <= seg_last_next;
    end

    // range registers
    assign cfg_hit = cfg_valid && (cfg_index[CFG_IDX_W-1:1] <= RNG_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbase_reg[0] <= RST_BASE_A;
            rsize_reg[0] <= RST_SIZE_A;
            rbase_reg[1] <= RST_BASE_B;
            rsize_reg[1] <= RST_SIZE_B;
            rbase_reg[2] <= RST_BASE_C;
            rsize_reg[2] <= RST_SIZE_C;
        end
        else if (cfg_hit)
        begin
            if (cfg_index[0] == CFG_SEL_SIZE)
                rsize_reg[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
            else if (cfg_index[0] == CFG_SEL_BASE)
                rbase_reg[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign seg_valid      = seg_valid_reg;
    assign seg_base       = seg_base_reg;
    assign seg_length     = seg_length_reg;
    assign seg_kind       = seg_kind_reg;
    assign seg_attributes = seg_attr_reg;
    assign seg_last       = seg_last_reg;

endmodule

`default_nettype wire
